// File: hdl/scta_pkg.sv
package scta_pkg;

  typedef enum logic [1:0] {
    ACT_SCAN  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_CLEAR = 2'd2
  } action_t;

  localparam logic [7:0] REL_BIT    = 8'h80;
  localparam logic [6:0] CODE_MASK  = 7'h7F;
  localparam logic [6:0] KEY_LSHIFT = 7'h2A;
  localparam logic [6:0] KEY_RSHIFT = 7'h36;
  localparam logic [6:0] KEY_CTRL   = 7'h1D;
  localparam logic [6:0] KEY_ALT    = 7'h38;
  localparam logic [6:0] KEY_CAPS   = 7'h3A;
  localparam logic [6:0] CASE_BIT   = 7'h20;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] scan_code;
  } cmd_t;

  typedef struct packed {
    logic [6:0] read_char;
    logic       read_valid;
    logic       char_available;
    logic       dropped_full;
    logic       shift_held;
    logic       ctrl_held;
    logic       alt_held;
    logic       caps_on;
  } rsp_t;

  typedef struct packed {
    logic shift;
    logic ctrl;
    logic alt;
    logic caps;
  } mods_t;

  // status carried alongside a pending memory read
  typedef struct packed {
    logic  rd;
    logic  avail;
    logic  dropped;
    mods_t mods;
  } meta_t;

  function automatic logic [6:0] plain_char(input logic [6:0] code);
    logic [6:0] c;
    unique case (code)
      7'h01: c = 7'h1B;  7'h02: c = 7'h31;  7'h03: c = 7'h32;  7'h04: c = 7'h33;
      7'h05: c = 7'h34;  7'h06: c = 7'h35;  7'h07: c = 7'h36;  7'h08: c = 7'h37;
      7'h09: c = 7'h38;  7'h0A: c = 7'h39;  7'h0B: c = 7'h30;  7'h0C: c = 7'h2D;
      7'h0D: c = 7'h3D;  7'h0E: c = 7'h08;  7'h0F: c = 7'h09;  7'h10: c = 7'h71;
      7'h11: c = 7'h77;  7'h12: c = 7'h65;  7'h13: c = 7'h72;  7'h14: c = 7'h74;
      7'h15: c = 7'h79;  7'h16: c = 7'h75;  7'h17: c = 7'h69;  7'h18: c = 7'h6F;
      7'h19: c = 7'h70;  7'h1A: c = 7'h5B;  7'h1B: c = 7'h5D;  7'h1C: c = 7'h0A;
      7'h1E: c = 7'h61;  7'h1F: c = 7'h73;  7'h20: c = 7'h64;  7'h21: c = 7'h66;
      7'h22: c = 7'h67;  7'h23: c = 7'h68;  7'h24: c = 7'h6A;  7'h25: c = 7'h6B;
      7'h26: c = 7'h6C;  7'h27: c = 7'h3B;  7'h28: c = 7'h27;  7'h29: c = 7'h60;
      7'h2B: c = 7'h5C;  7'h2C: c = 7'h7A;  7'h2D: c = 7'h78;  7'h2E: c = 7'h63;
      7'h2F: c = 7'h76;  7'h30: c = 7'h62;  7'h31: c = 7'h6E;  7'h32: c = 7'h6D;
      7'h33: c = 7'h2C;  7'h34: c = 7'h2E;  7'h35: c = 7'h2F;  7'h37: c = 7'h2A;
      7'h39: c = 7'h20;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  function automatic logic [6:0] upper_char(input logic [6:0] code);
    logic [6:0] c;
    unique case (code)
      7'h01: c = 7'h1B;  7'h02: c = 7'h21;  7'h03: c = 7'h40;  7'h04: c = 7'h23;
      7'h05: c = 7'h24;  7'h06: c = 7'h25;  7'h07: c = 7'h5E;  7'h08: c = 7'h26;
      7'h09: c = 7'h2A;  7'h0A: c = 7'h28;  7'h0B: c = 7'h29;  7'h0C: c = 7'h5F;
      7'h0D: c = 7'h2B;  7'h0E: c = 7'h08;  7'h0F: c = 7'h09;  7'h10: c = 7'h51;
      7'h11: c = 7'h57;  7'h12: c = 7'h45;  7'h13: c = 7'h52;  7'h14: c = 7'h54;
      7'h15: c = 7'h59;  7'h16: c = 7'h55;  7'h17: c = 7'h49;  7'h18: c = 7'h4F;
      7'h19: c = 7'h50;  7'h1A: c = 7'h7B;  7'h1B: c = 7'h7D;  7'h1C: c = 7'h0A;
      7'h1E: c = 7'h41;  7'h1F: c = 7'h53;  7'h20: c = 7'h44;  7'h21: c = 7'h46;
      7'h22: c = 7'h47;  7'h23: c = 7'h48;  7'h24: c = 7'h4A;  7'h25: c = 7'h4B;
      7'h26: c = 7'h4C;  7'h27: c = 7'h3A;  7'h28: c = 7'h22;  7'h29: c = 7'h7E;
      7'h2B: c = 7'h7C;  7'h2C: c = 7'h5A;  7'h2D: c = 7'h58;  7'h2E: c = 7'h43;
      7'h2F: c = 7'h56;  7'h30: c = 7'h42;  7'h31: c = 7'h4E;  7'h32: c = 7'h4D;
      7'h33: c = 7'h3C;  7'h34: c = 7'h3E;  7'h35: c = 7'h3F;  7'h37: c = 7'h2A;
      7'h39: c = 7'h20;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

endpackage

// File: hdl/scta_keymap.sv
module scta_keymap (
  input  logic                clk,
  input  logic                rst,
  input  logic                scan,
  input  logic [7:0]          scan_code,
  output logic [6:0]          key_char,
  output scta_pkg::mods_t     mods_next
);

  scta_pkg::mods_t mods;
  logic [6:0]      code;
  logic [6:0]      raw;
  logic            release_key;
  logic            is_shift;
  logic            is_mod;
  logic            is_alpha;

  assign code        = scan_code[6:0] & scta_pkg::CODE_MASK;
  assign release_key = |(scan_code & scta_pkg::REL_BIT);
  assign is_shift    = (code == scta_pkg::KEY_LSHIFT) || (code == scta_pkg::KEY_RSHIFT);
  assign is_mod      = is_shift || (code == scta_pkg::KEY_CTRL) ||
                       (code == scta_pkg::KEY_ALT) || (code == scta_pkg::KEY_CAPS);

  always_comb begin
    raw = mods.shift ? scta_pkg::upper_char(code) : scta_pkg::plain_char(code);
    is_alpha = ((raw >= 7'h41) && (raw <= 7'h5A)) || ((raw >= 7'h61) && (raw <= 7'h7A));
    key_char = 7'h00;
    if (scan && !release_key && !is_mod) begin
      key_char = (mods.caps && is_alpha) ? (raw ^ scta_pkg::CASE_BIT) : raw;
    end
  end

  always_comb begin
    mods_next = mods;
    if (scan) begin
      if (release_key) begin
        if (is_shift) begin
          mods_next.shift = 1'b0;
        end else if (code == scta_pkg::KEY_CTRL) begin
          mods_next.ctrl = 1'b0;
        end else if (code == scta_pkg::KEY_ALT) begin
          mods_next.alt = 1'b0;
        end
      end else if (is_shift) begin
        mods_next.shift = 1'b1;
      end else if (code == scta_pkg::KEY_CTRL) begin
        mods_next.ctrl = 1'b1;
      end else if (code == scta_pkg::KEY_ALT) begin
        mods_next.alt = 1'b1;
      end else if (code == scta_pkg::KEY_CAPS) begin
        mods_next.caps = ~mods.caps;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mods <= '0;
    end else begin
      mods <= mods_next;
    end
  end

endmodule

// File: hdl/scta_fifo.sv
module scta_fifo #(
  parameter int DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic [6:0] push_char,
  input  logic       pop,
  input  logic       clear,
  output logic       pop_ok,
  output logic       dropped,
  output logic       avail_next,
  output logic [6:0] rd_data
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(DEPTH - 1);

  logic [6:0]       mem [DEPTH];
  logic [IDX_W-1:0] rd_idx, wr_idx;
  logic [IDX_W-1:0] rd_idx_next, wr_idx_next;
  logic [IDX_W-1:0] wr_inc, rd_inc;
  logic             full;
  logic             push_ok;

  assign wr_inc  = (wr_idx == LAST) ? '0 : wr_idx + 1'b1;
  assign rd_inc  = (rd_idx == LAST) ? '0 : rd_idx + 1'b1;
  assign full    = (wr_inc == rd_idx);
  assign push_ok = push && !full;
  assign dropped = push && full;
  assign pop_ok  = pop && (rd_idx != wr_idx);

  always_comb begin
    rd_idx_next = rd_idx;
    wr_idx_next = wr_idx;
    if (clear) begin
      rd_idx_next = '0;
      wr_idx_next = '0;
    end else if (push_ok) begin
      wr_idx_next = wr_inc;
    end else if (pop_ok) begin
      rd_idx_next = rd_inc;
    end
  end

  assign avail_next = (rd_idx_next != wr_idx_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx <= '0;
      wr_idx <= '0;
    end else begin
      rd_idx <= rd_idx_next;
      wr_idx <= wr_idx_next;
    end
  end

  // a popped entry was always written at an earlier edge, so no bypass
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_idx] <= push_char;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_ok) begin
      rd_data <= mem[rd_idx];
    end
  end

endmodule

// File: hdl/scancode_to_ascii_with_fifo_top.sv
// channel  | direction | payload                | handshake
// cmd      | in        | scta_pkg::cmd_t        | cmd_valid / cmd_stall
// rsp      | out       | scta_pkg::rsp_t        | rsp_valid / rsp_stall
//
// One command per cycle while cmd_stall is low, one response per command.
// The character store is read in the cycle a pop is taken; its registered
// data joins the middle-stage status when that moves into the output register.
// rst clears indices, modifier flags and beat valids; store contents stay.
// A stalled response holds the middle stage, which then stalls cmd.
module scancode_to_ascii_with_fifo_top #(
  parameter int FIFO_DEPTH = 256
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_stall,
  input  scta_pkg::cmd_t  cmd,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output scta_pkg::rsp_t  rsp
);

  logic            accept;
  logic            is_scan, is_pop, is_clear;
  logic [6:0]      key_char;
  scta_pkg::mods_t mods_next;
  logic            pop_ok, dropped, avail_next;
  logic [6:0]      rd_data;
  logic            mid_valid;
  scta_pkg::meta_t mid;
  logic            mid_move;

  assign mid_move  = !(rsp_valid && rsp_stall);
  assign cmd_stall = mid_valid && !mid_move;
  assign accept    = cmd_valid && !cmd_stall;

  assign is_scan  = accept && (cmd.action == scta_pkg::ACT_SCAN);
  assign is_pop   = accept && (cmd.action == scta_pkg::ACT_POP);
  assign is_clear = accept && (cmd.action == scta_pkg::ACT_CLEAR);

  scta_keymap u_keymap (
    .clk       (clk),
    .rst       (rst),
    .scan      (is_scan),
    .scan_code (cmd.scan_code),
    .key_char  (key_char),
    .mods_next (mods_next)
  );

  scta_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (is_scan && (key_char != 7'h00)),
    .push_char  (key_char),
    .pop        (is_pop),
    .clear      (is_clear),
    .pop_ok     (pop_ok),
    .dropped    (dropped),
    .avail_next (avail_next),
    .rd_data    (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (accept) begin
      mid_valid <= 1'b1;
    end else if (mid_move) begin
      mid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mid.rd      <= pop_ok;
      mid.avail   <= avail_next;
      mid.dropped <= dropped;
      mid.mods    <= mods_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (mid_move) begin
      rsp_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_move && mid_valid) begin
      rsp.read_char      <= mid.rd ? rd_data : 7'h00;
      rsp.read_valid     <= mid.rd;
      rsp.char_available <= mid.avail;
      rsp.dropped_full   <= mid.dropped;
      rsp.shift_held     <= mid.mods.shift;
      rsp.ctrl_held      <= mid.mods.ctrl;
      rsp.alt_held       <= mid.mods.alt;
      rsp.caps_on        <= mid.mods.caps;
    end
  end

endmodule

// File: tb/sv/scancode_checker.sv
`timescale 1ns / 1ps

module scancode_checker #(
  parameter int FIFO_DEPTH = 256
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  logic           cmd_stall,
  input  scta_pkg::cmd_t cmd,
  input  logic           rsp_valid,
  input  logic           rsp_stall,
  input  scta_pkg::rsp_t rsp,
  output int             errors,
  output int             pending
);

  // US layout, codes 0..57; above that the map holds nothing.
  // '~' and '0' stand for "no character" in the two rows.
  localparam byte unsigned PLAIN_NONE = "~";
  localparam byte unsigned SHIFT_NONE = "0";
  string plain_keys = "~\0331234567890-=\010\tqwertyuiop[]\n~asdfghjkl;'\140~\\zxcvbnm,./~*~ ";
  string shift_keys = "0\033!@#$%^&*()_+\010\tQWERTYUIOP{}\n0ASDFGHJKL:\"~0|ZXCVBNM<>?0*0 ";

  logic [6:0]     char_mem [FIFO_DEPTH];
  int unsigned    rd_ptr, wr_ptr;
  logic           shift_q, ctrl_q, alt_q, caps_q;
  scta_pkg::rsp_t want_q [$];

  function automatic logic [6:0] key_char(input logic [6:0] code);
    byte unsigned ch;
    if (code > 7'd57) return 7'd0;
    if (shift_q) begin
      ch = shift_keys[code];
      if (ch == SHIFT_NONE) ch = 0;
    end else begin
      ch = plain_keys[code];
      if (ch == PLAIN_NONE) ch = 0;
    end
    if (caps_q && ((ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z")))
      ch = ch ^ {1'b0, scta_pkg::CASE_BIT};
    return ch[6:0];
  endfunction

  task automatic step_keyboard(input scta_pkg::cmd_t c, output scta_pkg::rsp_t r);
    logic [6:0]  code;
    logic [6:0]  ch;
    int unsigned nxt;
    r    = '0;
    code = c.scan_code[6:0] & scta_pkg::CODE_MASK;
    case (c.action)
      scta_pkg::ACT_SCAN: begin
        if ((c.scan_code & scta_pkg::REL_BIT) != 0) begin
          if (code == scta_pkg::KEY_LSHIFT || code == scta_pkg::KEY_RSHIFT) shift_q = 1'b0;
          else if (code == scta_pkg::KEY_CTRL) ctrl_q = 1'b0;
          else if (code == scta_pkg::KEY_ALT) alt_q = 1'b0;
        end else if (code == scta_pkg::KEY_LSHIFT || code == scta_pkg::KEY_RSHIFT) begin
          shift_q = 1'b1;
        end else if (code == scta_pkg::KEY_CTRL) begin
          ctrl_q = 1'b1;
        end else if (code == scta_pkg::KEY_ALT) begin
          alt_q = 1'b1;
        end else if (code == scta_pkg::KEY_CAPS) begin
          caps_q = !caps_q;
        end else begin
          ch = key_char(code);
          if (ch != 0) begin
            nxt = (wr_ptr + 1) % FIFO_DEPTH;
            if (nxt == rd_ptr) begin
              r.dropped_full = 1'b1;
            end else begin
              char_mem[wr_ptr] = ch;
              wr_ptr = nxt;
            end
          end
        end
      end
      scta_pkg::ACT_POP: begin
        if (rd_ptr != wr_ptr) begin
          r.read_char  = char_mem[rd_ptr];
          r.read_valid = 1'b1;
          rd_ptr = (rd_ptr + 1) % FIFO_DEPTH;
        end
      end
      scta_pkg::ACT_CLEAR: begin
        rd_ptr = 0;
        wr_ptr = 0;
      end
      default: ;
    endcase
    r.char_available = (rd_ptr != wr_ptr);
    r.shift_held     = shift_q;
    r.ctrl_held      = ctrl_q;
    r.alt_held       = alt_q;
    r.caps_on        = caps_q;
  endtask

  task automatic cmp(input string field, input logic [6:0] want, input logic [6:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    scta_pkg::rsp_t want;
    scta_pkg::rsp_t next_want;
    if (rst) begin
      rd_ptr  = 0;
      wr_ptr  = 0;
      shift_q = 1'b0;
      ctrl_q  = 1'b0;
      alt_q   = 1'b0;
      caps_q  = 1'b0;
      want_q.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (want_q.size() == 0) begin
          errors++;
          $display("%0t: response beat with nothing expected, expected none, got 0x%0h",
                   $time, rsp);
        end else begin
          want = want_q.pop_front();
          cmp("read_char",      want.read_char,      rsp.read_char);
          cmp("read_valid",     want.read_valid,     rsp.read_valid);
          cmp("char_available", want.char_available, rsp.char_available);
          cmp("dropped_full",   want.dropped_full,   rsp.dropped_full);
          cmp("shift_held",     want.shift_held,     rsp.shift_held);
          cmp("ctrl_held",      want.ctrl_held,      rsp.ctrl_held);
          cmp("alt_held",       want.alt_held,       rsp.alt_held);
          cmp("caps_on",        want.caps_on,        rsp.caps_on);
        end
      end
      if (cmd_valid && !cmd_stall) begin
        step_keyboard(cmd, next_want);
        want_q.push_back(next_want);
      end
    end
    pending = want_q.size();
  end

endmodule

// File: tb/sv/tb_scancode_to_ascii_with_fifo_top.sv
`timescale 1ns / 1ps

module tb_scancode_to_ascii_with_fifo_top;

  localparam int FIFO_DEPTH   = 256;
  localparam int RANDOM_BEATS = 950;
  localparam int CYCLE_LIMIT  = 300000;

  localparam logic [1:0] ACT_SPARE = 2'd3;

  localparam logic [7:0] SC_NULL     = 8'h00;
  localparam logic [7:0] SC_ESC      = 8'h01;
  localparam logic [7:0] SC_ONE      = 8'h02;
  localparam logic [7:0] SC_A        = 8'h1E;
  localparam logic [7:0] SC_SPACE    = 8'h39;
  localparam logic [7:0] SC_LAST_ROW = 8'h44;
  localparam logic [7:0] SC_PAST_MAP = 8'h45;
  localparam logic [7:0] SC_TOP      = 8'h7F;
  localparam logic [7:0] SC_ALL      = 8'hFF;
  localparam logic [7:0] SC_Q        = 8'h10;
  localparam logic [7:0] SC_P        = 8'h19;

  logic           clk;
  logic           rst;
  logic           cmd_valid;
  logic           cmd_stall;
  scta_pkg::cmd_t cmd;
  logic           rsp_valid;
  logic           rsp_stall;
  scta_pkg::rsp_t rsp;

  int errors;
  int pending;
  int cycles;
  bit tx_lively;
  int beats, n_scan, n_pop, n_clear, n_spare, n_floods;

  scancode_to_ascii_with_fifo_top #(.FIFO_DEPTH(FIFO_DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  scancode_checker #(.FIFO_DEPTH(FIFO_DEPTH)) u_check (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d responses outstanding", cycles, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int idle_draw(input bit lively);
    if (!lively) return 0;
    return ($urandom_range(0, 1) == 1) ? $urandom_range(0, 15) : 0;
  endfunction

  function automatic logic [7:0] key_up(input logic [6:0] k);
    return scta_pkg::REL_BIT | {1'b0, k};
  endfunction

  // Leaves at the edge that takes the beat, valid still high.
  task automatic send(input logic [1:0] act, input logic [7:0] code);
    int             gap;
    scta_pkg::cmd_t beat;
    gap = idle_draw(tx_lively);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    beat.action    = act;
    beat.scan_code = code;
    cmd       <= beat;
    cmd_valid <= 1'b1;
    @(negedge clk);
    while (cmd_stall) @(negedge clk);
    @(posedge clk);
    case (act)
      scta_pkg::ACT_SCAN:  n_scan++;
      scta_pkg::ACT_POP:   n_pop++;
      scta_pkg::ACT_CLEAR: n_clear++;
      default:             n_spare++;
    endcase
    if (act != ACT_SPARE) beats++;
  endtask

  task automatic wait_quiet();
    cmd_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic modifier_beat();
    logic [6:0] k;
    case ($urandom_range(0, 4))
      0:       k = scta_pkg::KEY_LSHIFT;
      1:       k = scta_pkg::KEY_RSHIFT;
      2:       k = scta_pkg::KEY_CTRL;
      3:       k = scta_pkg::KEY_ALT;
      default: k = scta_pkg::KEY_CAPS;
    endcase
    send(scta_pkg::ACT_SCAN, ($urandom_range(0, 1) == 1) ? key_up(k) : {1'b0, k});
  endtask

  // letter keys always decode, so the ring is full well before the end
  task automatic flood_fifo();
    n_floods++;
    repeat (FIFO_DEPTH + 4) send(scta_pkg::ACT_SCAN, 8'($urandom_range(SC_Q, SC_P)));
    wait_quiet();
    repeat (FIFO_DEPTH + 2) send(scta_pkg::ACT_POP, 8'($urandom_range(0, 255)));
  endtask

  task automatic typing_burst();
    int pick;
    repeat ($urandom_range(4, 20)) begin
      pick = $urandom_range(0, 99);
      if (pick < 30)      send(scta_pkg::ACT_POP, 8'($urandom_range(0, 255)));
      else if (pick < 42) modifier_beat();
      else if (pick < 90) send(scta_pkg::ACT_SCAN, 8'($urandom_range(0, 68)));
      else if (pick < 95) send(scta_pkg::ACT_SCAN, 8'($urandom_range(0, 255)));
      else if (pick < 98) send(scta_pkg::ACT_CLEAR, 8'($urandom_range(0, 255)));
      else                send(ACT_SPARE, 8'($urandom_range(0, 255)));
    end
  endtask

  // response side: stall for a drawn number of cycles, then take one beat
  initial begin : rsp_side
    int wait_n;
    int run_len;
    bit rx_lively;
    rsp_stall = 1'b0;
    run_len = 0;
    @(posedge clk);
    forever begin
      if (run_len == 0) begin
        rx_lively = ($urandom_range(0, 2) != 0);
        run_len   = $urandom_range(20, 60);
      end
      run_len--;
      wait_n = idle_draw(rx_lively);
      if (wait_n > 0) begin
        rsp_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      @(negedge clk);
      while (!rsp_valid) @(negedge clk);
      @(posedge clk);
    end
  end

  initial begin : stimulus
    int start;
    int pick;
    rst       = 1'b1;
    cmd_valid = 1'b0;
    cmd       = '0;
    tx_lively = 1'b0;
    beats = 0; n_scan = 0; n_pop = 0; n_clear = 0; n_spare = 0; n_floods = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // empty buffer, unused code, keys that decode to nothing, then escape and a letter
    send(scta_pkg::ACT_POP, SC_ALL);
    send(scta_pkg::ACT_CLEAR, SC_ALL);
    send(ACT_SPARE, SC_ALL);
    send(scta_pkg::ACT_SCAN, SC_NULL);
    send(scta_pkg::ACT_SCAN, SC_PAST_MAP);
    send(scta_pkg::ACT_SCAN, SC_LAST_ROW);
    send(scta_pkg::ACT_SCAN, SC_TOP);
    send(scta_pkg::ACT_SCAN, SC_ESC);
    send(scta_pkg::ACT_SCAN, SC_A);
    // shift: either key sets, either release clears
    send(scta_pkg::ACT_SCAN, {1'b0, scta_pkg::KEY_LSHIFT});
    send(scta_pkg::ACT_SCAN, SC_A);
    send(scta_pkg::ACT_SCAN, SC_ONE);
    send(scta_pkg::ACT_SCAN, key_up(scta_pkg::KEY_RSHIFT));
    send(scta_pkg::ACT_SCAN, {1'b0, scta_pkg::KEY_RSHIFT});
    send(scta_pkg::ACT_SCAN, key_up(scta_pkg::KEY_LSHIFT));
    // caps lock toggles on press only, and inverts case under shift; then ctrl, alt, pops, clear
    tx_lively = 1'b1;
    send(scta_pkg::ACT_SCAN, {1'b0, scta_pkg::KEY_CAPS});
    send(scta_pkg::ACT_SCAN, SC_A);
    send(scta_pkg::ACT_SCAN, key_up(scta_pkg::KEY_CAPS));
    send(scta_pkg::ACT_SCAN, {1'b0, scta_pkg::KEY_LSHIFT});
    send(scta_pkg::ACT_SCAN, SC_A);
    send(scta_pkg::ACT_SCAN, key_up(scta_pkg::KEY_LSHIFT));
    send(scta_pkg::ACT_SCAN, {1'b0, scta_pkg::KEY_CAPS});
    send(scta_pkg::ACT_SCAN, {1'b0, scta_pkg::KEY_CTRL});
    send(scta_pkg::ACT_SCAN, {1'b0, scta_pkg::KEY_ALT});
    send(scta_pkg::ACT_SCAN, SC_SPACE);
    send(scta_pkg::ACT_SCAN, key_up(scta_pkg::KEY_CTRL));
    send(scta_pkg::ACT_SCAN, key_up(scta_pkg::KEY_ALT));
    send(scta_pkg::ACT_SCAN, key_up(SC_A[6:0]));
    send(scta_pkg::ACT_POP, SC_NULL);
    send(scta_pkg::ACT_POP, SC_ALL);
    send(scta_pkg::ACT_CLEAR, SC_NULL);
    send(scta_pkg::ACT_POP, SC_NULL);

    start = beats;
    tx_lively = 1'b0;
    flood_fifo();
    while (beats - start < RANDOM_BEATS) begin
      tx_lively = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        typing_burst();
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 30)) send(scta_pkg::ACT_POP, 8'($urandom_range(0, 255)));
      end else if (pick < 98 || beats - start > RANDOM_BEATS - 600) begin
        repeat ($urandom_range(5, 15))
          send(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end else begin
        flood_fifo();
      end
    end

    wait_quiet();
    repeat (8) @(posedge clk);
    $display("Ran %0d scancodes, %0d pops, %0d clears and %0d unused-code beats,",
             n_scan, n_pop, n_clear, n_spare);
    $display("with %0d fill-to-overflow passes and random stalls on both sides.", n_floods);
    if (errors == 0 && pending == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
